### hw/rtl/assert_macros.svh
// Assertion macros for the project's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define ASSERT_IMPL(label, clk, rst, a, c)
`define ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### hw/rtl/dft14_pkg.sv
// ----------------------------------------------------------------------------
// dft14_pkg
// Shared constants and types for the radix-14 real DFT block.
// ----------------------------------------------------------------------------
package dft14_pkg;
  localparam int FRAME_LEN = 14;
  localparam int VALUE_W = 24;
  localparam int POS_W = 4;
  localparam logic [POS_W-1:0] LAST_POS = 4'd13;

  // cos/sin of k*pi/7 at 32 fraction bits.
  localparam logic [31:0] MASTER_COEF [6] = '{
    32'd3869631822, 32'd1863516470, 32'd2677868308,
    32'd3357940648, 32'd955720134, 32'd4187283499
  };

  typedef enum logic [2:0] {
    ST_FILL = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic emit;
    logic [POS_W-1:0] pos;
  } dft14_cmd_t;
endpackage

### hw/rtl/dft14_ctrl.sv
// ----------------------------------------------------------------------------
// dft14_ctrl
// Sequencer: fills a frame, runs the transform, streams fourteen values.
// ----------------------------------------------------------------------------
module dft14_ctrl import dft14_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic calc_done,
  output logic busy,
  output dft14_cmd_t cmd
);
  state_t state, state_next;
  logic [POS_W-1:0] fill_count, pos;

  assign busy = (state != ST_FILL);
  assign cmd.load = start && (state == ST_FILL);
  assign cmd.calc = (state == ST_CALC);
  assign cmd.emit = (state == ST_EMIT);
  assign cmd.pos = pos;

  always_comb begin
    state_next = state;
    case (state)
      ST_FILL: if (start && fill_count == LAST_POS) state_next = ST_CALC;
      ST_CALC: if (calc_done) state_next = ST_EMIT;
      ST_EMIT: if (pos == LAST_POS) state_next = ST_FILL;
      default: state_next = ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      fill_count <= '0;
      pos <= '0;
    end else begin
      state <= state_next;
      if (cmd.load) fill_count <= (fill_count == LAST_POS) ? '0 : fill_count + 1'b1;
      if (cmd.emit) pos <= (pos == LAST_POS) ? '0 : pos + 1'b1;
    end
  end
endmodule

### hw/rtl/dft14_dp.sv
// ----------------------------------------------------------------------------
// dft14_dp
// Datapath: frame buffer, one shared rounding multiplier, accumulator.
// A micro-program of multiply-accumulate steps builds the other output values; two are formed from sums alone.
// ----------------------------------------------------------------------------
module dft14_dp import dft14_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  dft14_cmd_t cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic inverse_mode,
  output logic calc_done,
  output logic signed [VALUE_W-1:0] value
);
  localparam int AW = SAMPLE_WIDTH + 8;
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = AW + CW;

  // Coefficient k (0..5), forward or doubled for inverse.
  function automatic logic [CW-1:0] coef(input logic [2:0] k, input logic inv);
    logic [32:0] m;
    logic [32:0] r;
    begin
      m = {1'b0, MASTER_COEF[k]};
      if (inv) r = (m + (33'd1 << (30 - COEF_FRAC_BITS))) >> (31 - COEF_FRAC_BITS);
      else     r = (m + (33'd1 << (31 - COEF_FRAC_BITS))) >> (32 - COEF_FRAC_BITS);
      coef = r[CW-1:0];
    end
  endfunction

  logic signed [SAMPLE_WIDTH-1:0] buf_q [FRAME_LEN];
  logic [3:0] wr_idx;
  logic signed [AW-1:0] res [FRAME_LEN];

  // Butterfly sums, registered.
  logic signed [AW-1:0] bp [7];
  logic signed [AW-1:0] bd [7];
  logic signed [AW-1:0] tA [3];
  logic signed [AW-1:0] tB [3];
  logic signed [AW-1:0] tC [3];
  logic signed [AW-1:0] tD [3];

  // Step counter: step 0 captures butterflies, step 1 forms the groups,
  // steps 2..37 issue the 36 products, step 40 ends the calculation.
  logic [5:0] step;
  logic [2:0] out_k;

  // Term table per step: source operand, coefficient, sign.
  logic signed [AW-1:0] op;
  logic [2:0] ck;
  logic neg;
  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] pr;
  logic signed [AW-1:0] accu, accv;

  function automatic logic signed [AW-1:0] sx(input logic signed [SAMPLE_WIDTH-1:0] a);
    sx = AW'(a);
  endfunction

  // Schedule: out_k selects row 1..6, step within row selects term 0..5.
  logic [2:0] term;
  always_comb begin
    op = '0; ck = '0; neg = 1'b0;
    if (!inverse_mode) begin
      // terms 0..2 -> real row, 3..5 -> imag row
      case ({out_k, term})
        {3'd1,3'd0}: begin op = tB[0]; ck = 3'd0; neg = 1'b1; end
        {3'd1,3'd1}: begin op = tB[1]; ck = 3'd2; end
        {3'd1,3'd2}: begin op = tB[2]; ck = 3'd4; neg = 1'b1; end
        {3'd1,3'd3}: begin op = tC[0]; ck = 3'd1; end
        {3'd1,3'd4}: begin op = tC[1]; ck = 3'd3; end
        {3'd1,3'd5}: begin op = tC[2]; ck = 3'd5; end
        {3'd2,3'd0}: begin op = tA[2]; ck = 3'd0; neg = 1'b1; end
        {3'd2,3'd1}: begin op = tA[0]; ck = 3'd2; end
        {3'd2,3'd2}: begin op = tA[1]; ck = 3'd4; neg = 1'b1; end
        {3'd2,3'd3}: begin op = tD[2]; ck = 3'd1; end
        {3'd2,3'd4}: begin op = tD[0]; ck = 3'd3; end
        {3'd2,3'd5}: begin op = tD[1]; ck = 3'd5; end
        {3'd3,3'd0}: begin op = tB[1]; ck = 3'd0; neg = 1'b1; end
        {3'd3,3'd1}: begin op = tB[2]; ck = 3'd2; end
        {3'd3,3'd2}: begin op = tB[0]; ck = 3'd4; neg = 1'b1; end
        {3'd3,3'd3}: begin op = tC[1]; ck = 3'd1; end
        {3'd3,3'd4}: begin op = tC[2]; ck = 3'd3; neg = 1'b1; end
        {3'd3,3'd5}: begin op = tC[0]; ck = 3'd5; end
        {3'd4,3'd0}: begin op = tA[1]; ck = 3'd0; neg = 1'b1; end
        {3'd4,3'd1}: begin op = tA[2]; ck = 3'd2; end
        {3'd4,3'd2}: begin op = tA[0]; ck = 3'd4; neg = 1'b1; end
        {3'd4,3'd3}: begin op = tD[1]; ck = 3'd1; neg = 1'b1; end
        {3'd4,3'd4}: begin op = tD[2]; ck = 3'd3; neg = 1'b1; end
        {3'd4,3'd5}: begin op = tD[0]; ck = 3'd5; end
        {3'd5,3'd0}: begin op = tB[2]; ck = 3'd0; neg = 1'b1; end
        {3'd5,3'd1}: begin op = tB[0]; ck = 3'd2; end
        {3'd5,3'd2}: begin op = tB[1]; ck = 3'd4; neg = 1'b1; end
        {3'd5,3'd3}: begin op = tC[2]; ck = 3'd1; end
        {3'd5,3'd4}: begin op = tC[0]; ck = 3'd3; end
        {3'd5,3'd5}: begin op = tC[1]; ck = 3'd5; neg = 1'b1; end
        {3'd6,3'd0}: begin op = tA[0]; ck = 3'd0; neg = 1'b1; end
        {3'd6,3'd1}: begin op = tA[1]; ck = 3'd2; end
        {3'd6,3'd2}: begin op = tA[2]; ck = 3'd4; neg = 1'b1; end
        {3'd6,3'd3}: begin op = tD[0]; ck = 3'd1; end
        {3'd6,3'd4}: begin op = tD[1]; ck = 3'd3; neg = 1'b1; end
        {3'd6,3'd5}: begin op = tD[2]; ck = 3'd5; end
        default: begin op = '0; ck = '0; neg = 1'b0; end
      endcase
    end else begin
      // inverse: terms 0..2 build u, 3..5 build v. k1=c(1),k2=c(0),k3=c(3),
      // k4=c(2),k5=c(5),k6=c(4). tA: da,dc,de  tB: pa,pc,pe  tC: pb,pd,pf
      // tD: db,dd,df
      case ({out_k, term})
        {3'd1,3'd0}: begin op = tA[1]; ck = 3'd2; end
        {3'd1,3'd1}: begin op = tA[2]; ck = 3'd4; neg = 1'b1; end
        {3'd1,3'd2}: begin op = tA[0]; ck = 3'd0; neg = 1'b1; end
        {3'd1,3'd3}: begin op = tC[0]; ck = 3'd1; end
        {3'd1,3'd4}: begin op = tC[1]; ck = 3'd3; end
        {3'd1,3'd5}: begin op = tC[2]; ck = 3'd5; end
        {3'd2,3'd0}: begin op = tB[0]; ck = 3'd2; end
        {3'd2,3'd1}: begin op = tB[2]; ck = 3'd0; neg = 1'b1; end
        {3'd2,3'd2}: begin op = tB[1]; ck = 3'd4; neg = 1'b1; end
        {3'd2,3'd3}: begin op = tD[2]; ck = 3'd1; end
        {3'd2,3'd4}: begin op = tD[0]; ck = 3'd3; end
        {3'd2,3'd5}: begin op = tD[1]; ck = 3'd5; end
        {3'd3,3'd0}: begin op = tA[2]; ck = 3'd2; end
        {3'd3,3'd1}: begin op = tA[1]; ck = 3'd0; neg = 1'b1; end
        {3'd3,3'd2}: begin op = tA[0]; ck = 3'd4; neg = 1'b1; end
        {3'd3,3'd3}: begin op = tC[2]; ck = 3'd3; end
        {3'd3,3'd4}: begin op = tC[1]; ck = 3'd1; neg = 1'b1; end
        {3'd3,3'd5}: begin op = tC[0]; ck = 3'd5; neg = 1'b1; end
        {3'd4,3'd0}: begin op = tB[2]; ck = 3'd2; end
        {3'd4,3'd1}: begin op = -tB[0]; ck = 3'd4; end
        {3'd4,3'd2}: begin op = tB[1]; ck = 3'd0; neg = 1'b1; end
        {3'd4,3'd3}: begin op = tD[1]; ck = 3'd1; end
        {3'd4,3'd4}: begin op = tD[2]; ck = 3'd3; end
        {3'd4,3'd5}: begin op = tD[0]; ck = 3'd5; neg = 1'b1; end
        {3'd5,3'd0}: begin op = tA[0]; ck = 3'd2; end
        {3'd5,3'd1}: begin op = tA[2]; ck = 3'd0; neg = 1'b1; end
        {3'd5,3'd2}: begin op = tA[1]; ck = 3'd4; neg = 1'b1; end
        {3'd5,3'd3}: begin op = tC[1]; ck = 3'd5; end
        {3'd5,3'd4}: begin op = tC[2]; ck = 3'd1; neg = 1'b1; end
        {3'd5,3'd5}: begin op = tC[0]; ck = 3'd3; neg = 1'b1; end
        {3'd6,3'd0}: begin op = tB[1]; ck = 3'd2; end
        {3'd6,3'd1}: begin op = tB[0]; ck = 3'd0; neg = 1'b1; end
        {3'd6,3'd2}: begin op = tB[2]; ck = 3'd4; neg = 1'b1; end
        {3'd6,3'd3}: begin op = tD[1]; ck = 3'd3; end
        {3'd6,3'd4}: begin op = tD[0]; ck = 3'd1; neg = 1'b1; end
        {3'd6,3'd5}: begin op = tD[2]; ck = 3'd5; neg = 1'b1; end
        default: begin op = '0; ck = '0; neg = 1'b0; end
      endcase
    end
  end

  // Pipeline: a term is issued; product registered; accumulate next cycle.
  logic issue_v, acc_v, acc_neg, acc_last;
  logic [2:0] acc_term, acc_k;
  logic [2:0] acc_idx;
  assign pr = AW'((prod + (PW'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS);
  assign calc_done = (step == 6'd40);

  always_ff @(posedge clk) begin
    if (cmd.load) buf_q[wr_idx] <= sample;
    if (rst) begin
      wr_idx <= '0;
      step <= '0;
      issue_v <= 1'b0;
      acc_v <= 1'b0;
    end else begin
      if (cmd.load) wr_idx <= (wr_idx == LAST_POS) ? '0 : wr_idx + 1'b1;
      if (cmd.calc) step <= step + 1'b1;
      else step <= '0;
      // The groups are ready after step 1, so issuing starts at step 2.
      if (cmd.calc && step == 6'd1) issue_v <= 1'b1;
      else if (issue_v && out_k == 3'd6 && term == 3'd5) issue_v <= 1'b0;
      acc_v <= issue_v;
    end
    // Row and term counters walk the 36 products in order.
    if (cmd.calc && step == 6'd1) begin
      out_k <= 3'd1;
      term <= '0;
    end else if (issue_v) begin
      if (term == 3'd5) begin
        term <= '0;
        out_k <= out_k + 3'd1;
      end else begin
        term <= term + 3'd1;
      end
    end
    prod <= $signed(op) * $signed({1'b0, coef(ck, inverse_mode)});
    acc_neg <= neg;
    acc_term <= term;
    acc_k <= out_k;
    acc_idx <= acc_k;
    if (acc_v) begin
      // forward rows: real -> res[2k-1], imag -> res[2k]
      // inverse rows: u -> accu, v -> accv
      if (acc_term == 3'd0) accu <= (acc_neg ? -pr : pr);
      else if (acc_term < 3'd3) accu <= accu + (acc_neg ? -pr : pr);
      else if (acc_term == 3'd3) accv <= (acc_neg ? -pr : pr);
      else accv <= accv + (acc_neg ? -pr : pr);
    end
    if (step == 6'd0 && cmd.calc) begin
      if (!inverse_mode) begin
        for (int i = 0; i < 7; i++) begin
          bp[i] <= (i == 0) ? sx(buf_q[0]) + sx(buf_q[7]) : sx(buf_q[14-i]) + sx(buf_q[i]);
          bd[i] <= (i == 0) ? sx(buf_q[0]) - sx(buf_q[7]) : sx(buf_q[14-i]) - sx(buf_q[i]);
        end
      end else begin
        bp[0] <= sx(buf_q[0]) + sx(buf_q[13]);
        bd[0] <= sx(buf_q[0]) - sx(buf_q[13]);
      end
    end
    if (step == 6'd1) begin
      if (!inverse_mode) begin
        tA[0] <= bp[1] + bp[6]; tA[1] <= bp[2] + bp[5]; tA[2] <= bp[3] + bp[4];
        tB[0] <= bp[6] - bp[1]; tB[1] <= bp[2] - bp[5]; tB[2] <= bp[4] - bp[3];
        tC[0] <= bd[1] + bd[6]; tC[1] <= bd[2] + bd[5]; tC[2] <= bd[3] + bd[4];
        tD[0] <= bd[1] - bd[6]; tD[1] <= bd[2] - bd[5]; tD[2] <= bd[3] - bd[4];
      end else begin
        tA[0] <= sx(buf_q[11]) - sx(buf_q[1]);
        tA[1] <= sx(buf_q[3]) - sx(buf_q[9]);
        tA[2] <= sx(buf_q[7]) - sx(buf_q[5]);
        tB[0] <= sx(buf_q[1]) + sx(buf_q[11]);
        tB[1] <= sx(buf_q[3]) + sx(buf_q[9]);
        tB[2] <= sx(buf_q[5]) + sx(buf_q[7]);
        tC[0] <= sx(buf_q[2]) + sx(buf_q[12]);
        tC[1] <= sx(buf_q[4]) + sx(buf_q[10]);
        tC[2] <= sx(buf_q[6]) + sx(buf_q[8]);
        tD[0] <= sx(buf_q[2]) - sx(buf_q[12]);
        tD[1] <= sx(buf_q[4]) - sx(buf_q[10]);
        tD[2] <= sx(buf_q[6]) - sx(buf_q[8]);
      end
    end
    if (step == 6'd2) begin
      if (!inverse_mode) begin
        res[0] <= bp[0] + tA[0] + tA[1] + tA[2];
        res[13] <= bd[0] + tB[0] + tB[1] + tB[2];
      end else begin
        res[0] <= ((tB[2] + tB[0] + tB[1]) <<< 1) + bp[0];
        res[7] <= ((tA[0] + tA[1] + tA[2]) <<< 1) + bd[0];
      end
    end
    // Row finished when its last v term has been accumulated.
    acc_last <= acc_v && acc_term == 3'd5;
    if (acc_last) begin
      if (!inverse_mode) begin
        res[4'(2*acc_idx-1)] <= accu + ((acc_idx[0]) ? bd[0] : bp[0]);
        res[4'(2*acc_idx)] <= accv;
      end else begin
        if (acc_idx <= 3'd2) begin
          res[4'(acc_idx)] <= accu + (acc_idx[0] ? bd[0] : bp[0]) - accv;
          res[4'(14-acc_idx)] <= accu + (acc_idx[0] ? bd[0] : bp[0]) + accv;
        end else begin
          res[4'(acc_idx)] <= accu + (acc_idx[0] ? bd[0] : bp[0]) + accv;
          res[4'(14-acc_idx)] <= accu + (acc_idx[0] ? bd[0] : bp[0]) - accv;
        end
      end
    end
    if (cmd.emit) value <= VALUE_W'(res[cmd.pos]);
  end
endmodule

### hw/rtl/real_dft14_pack_and_unpack.sv
// Samples load at one per cycle while busy is low; busy then keeps out the next
// frame while one shared rounding multiplier serves 36 products per frame.
// Reset (rst, synchronous) clears the sequencer, counts and batch flag;
// the receiver cannot stall, each value shows for one cycle with out_valid.
// ----------------------------------------------------------------------------
// real_dft14_pack_and_unpack
// Streaming radix-14 real DFT with half-complex packing, forward and inverse.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module real_dft14_pack_and_unpack import dft14_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic batch_end,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  output logic out_valid,
  output logic signed [VALUE_W-1:0] value,
  output logic [POS_W-1:0] position,
  output logic frame_last,
  output logic batch_done
);
  dft14_cmd_t cmd;
  logic calc_done, inverse_mode, batch_pending;

  assign cfg_ready = 1'b1;

  dft14_ctrl u_ctrl (.clk, .rst, .start, .calc_done, .busy, .cmd);
  dft14_dp #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .sample, .inverse_mode, .calc_done, .value);

  // The output value register holds a value in the cycle after its emit command.
  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_mode <= 1'b0;
      batch_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) inverse_mode <= cfg_data;
      out_valid <= cmd.emit;
      if (cmd.load && batch_end) batch_pending <= 1'b1;
      else if (cmd.emit && cmd.pos == LAST_POS) batch_pending <= 1'b0;
    end
    position <= cmd.pos;
    frame_last <= cmd.pos == LAST_POS;
    batch_done <= (cmd.pos == LAST_POS) && batch_pending;
  end

  `ASSERT_IMPL(a_no_load_busy, clk, rst, cmd.load, !busy)
  `ASSERT_NEXT(a_last_ends, clk, rst, out_valid && frame_last, !out_valid)
  `ASSERT_IMPL(a_done_last, clk, rst, batch_done, frame_last && out_valid)
endmodule
